[rtl/i2a_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

  localparam int VALUE_W         = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int BCD_W           = 4 * NUM_DIGITS;
  localparam int MAX_CHARS       = 10;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;

  localparam logic MODE_HEX = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_X    = 7'h78;
  localparam logic [6:0] CHAR_A    = 7'h41;

  typedef logic [6:0] char_t;
  typedef logic [3:0] count_t;

  // One word on its way through the conversion pipeline.
  typedef struct packed {
    logic                 mode;
    logic [VALUE_W-1:0]   value;
    logic [VALUE_W-1:0]   bin;
    logic [BCD_W-1:0]     bcd;
  } pipe_word_t;

  function automatic char_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_ZERO + 7'(nib);
    end
    return CHAR_A + 7'(nib - 4'd10);
  endfunction

  // Four shift-and-add-3 steps of the binary to BCD conversion.
  function automatic pipe_word_t dabble_stage(input pipe_word_t w);
    pipe_word_t r;
    logic [3:0] dig;
    r = w;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        dig = r.bcd[4*d +: 4];
        if (dig >= 4'd5) begin
          r.bcd[4*d +: 4] = dig + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/i2a_bcd_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2a_bcd_pipe import i2a_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               in_mode,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pipe_word_t              out_word
);

  logic       v_r   [NUM_STAGES];
  pipe_word_t w_r   [NUM_STAGES];
  logic       adv   [NUM_STAGES];
  pipe_word_t first_word;

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_comb begin
    first_word.mode  = in_mode;
    first_word.value = in_value;
    first_word.bin   = in_value;
    first_word.bcd   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      w_r[0] <= dabble_stage(first_word);
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (adv[i]) begin
        w_r[i] <= dabble_stage(w_r[i-1]);
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NUM_STAGES-1];
  assign out_word  = w_r[NUM_STAGES-1];

endmodule

`default_nettype wire

[rtl/integer_to_ascii_text.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                               Word
// input     in         in_valid, in_ready                  in_value[31:0], in_mode
// result    out        out_valid, out_ready                out_char_code[6:0], out_last
//
// A number enters every cycle while the pipeline has room. It passes through
// the binary to BCD stages and the format stage and then sits in the output
// shifter, which sends one character per cycle while out_ready is high: an
// item's text (1 to 10 characters) holds the result channel until its last one.
// Reset is synchronous and active low; it clears every valid bit.
// A stall on the result side backs up stage by stage; nothing is dropped.

module integer_to_ascii_text import i2a_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               in_mode,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output char_t                   out_char_code,
  output logic                    out_last
);

  logic       pipe_valid;
  logic       pipe_ready;
  pipe_word_t pipe_word;

  // The conversion pipeline works out all ten decimal digits for every word;
  // hex words simply carry their value along.
  i2a_bcd_pipe u_bcd_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .in_mode   (in_mode),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_word  (pipe_word)
  );

  // Format stage: left-aligned characters and the run length.
  logic   fmt_v_r;
  char_t  fmt_chars_r [MAX_CHARS];
  count_t fmt_len_r;
  char_t  fmt_chars_nxt [MAX_CHARS];
  count_t fmt_len_nxt;
  logic   fmt_take;

  // Output shifter: the head character is always at index zero.
  logic   ser_v_r;
  char_t  ser_chars_r [MAX_CHARS];
  count_t ser_cnt_r;
  logic   ser_load;
  logic   out_fire;

  logic [BCD_W-1:0]   bcd_aligned;
  logic [VALUE_W-1:0] hex_aligned;
  count_t             lead;
  logic               hit;
  logic [1:0]         skip;

  assign out_fire = out_valid && out_ready;

  // The shifter reloads when it is empty or when its last character leaves.
  assign ser_load   = fmt_v_r && (!ser_v_r || (out_fire && out_last));
  assign fmt_take   = !fmt_v_r || ser_load;
  assign pipe_ready = fmt_take;

  always_comb begin
    // Count leading zero digits; the lowest digit always shows.
    lead = '0;
    hit  = 1'b0;
    for (int i = 0; i < NUM_DIGITS - 1; i++) begin
      if (!hit) begin
        if (pipe_word.bcd[4*(NUM_DIGITS-1-i) +: 4] == 4'd0) begin
          lead = lead + 4'd1;
        end else begin
          hit = 1'b1;
        end
      end
    end
    bcd_aligned = pipe_word.bcd << {lead, 2'b00};

    // Skip the upper bytes that the value does not reach.
    if (pipe_word.value[31:24] != '0) begin
      skip = 2'd0;
    end else if (pipe_word.value[23:16] != '0) begin
      skip = 2'd1;
    end else if (pipe_word.value[15:8] != '0) begin
      skip = 2'd2;
    end else begin
      skip = 2'd3;
    end
    hex_aligned = pipe_word.value << {skip, 3'b000};

    if (pipe_word.mode == MODE_DEC) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        fmt_chars_nxt[i] = CHAR_ZERO + 7'(bcd_aligned[4*(NUM_DIGITS-1-i) +: 4]);
      end
      fmt_len_nxt = 4'(MAX_CHARS) - lead;
    end else begin
      fmt_chars_nxt[0] = CHAR_ZERO;
      fmt_chars_nxt[1] = CHAR_X;
      for (int j = 0; j < MAX_CHARS - 2; j++) begin
        fmt_chars_nxt[j+2] = hex_char(hex_aligned[4*(MAX_CHARS-3-j) +: 4]);
      end
      fmt_len_nxt = 4'(MAX_CHARS) - {1'b0, skip, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_v_r <= 1'b0;
    end else if (fmt_take) begin
      fmt_v_r <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fmt_take) begin
      fmt_chars_r <= fmt_chars_nxt;
      fmt_len_r   <= fmt_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      ser_cnt_r <= '0;
    end else if (ser_load) begin
      ser_v_r   <= 1'b1;
      ser_cnt_r <= fmt_len_r;
    end else if (out_fire) begin
      ser_v_r   <= !out_last;
      ser_cnt_r <= ser_cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_chars_r <= fmt_chars_r;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_CHARS - 1; i++) begin
        ser_chars_r[i] <= ser_chars_r[i+1];
      end
      ser_chars_r[MAX_CHARS-1] <= CHAR_ZERO;
    end
  end

  assign out_valid     = ser_v_r;
  assign out_char_code = ser_chars_r[0];
  assign out_last      = (ser_cnt_r == 4'd1);

endmodule

`default_nettype wire

[rtl/i2a_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2a_checker import i2a_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire char_t out_char_code,
  input wire logic  out_last
);

  // A stalled word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Reset empties the output shifter.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Only digits, uppercase hex letters and the x of the prefix are sent.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code >= 7'h30 && out_char_code <= 7'h39) ||
                   (out_char_code >= 7'h41 && out_char_code <= 7'h46) ||
                   out_char_code == CHAR_X))
    else $error("character outside the expected set");

  // The x of the prefix is never the final character of a number.
  a_x_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHAR_X |-> !out_last)
    else $error("prefix x flagged as last");

endmodule

bind integer_to_ascii_text i2a_checker u_i2a_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);

`default_nettype wire

[sim/integer_to_ascii_text_tb.sv]
`timescale 1ns / 1ps

module integer_to_ascii_text_tb;
  import i2a_pkg::*;

  localparam int RANDOM_NUMBERS = 450;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_WAIT       = 8;

  // One number waiting to be sent, and one character of its expected text.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               mode;
  } number_t;

  typedef struct {
    char_t code;
    logic  last;
  } text_char_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic               in_mode = MODE_HEX;
  logic               out_valid;
  logic               out_ready = 1'b0;
  char_t              out_char_code;
  logic               out_last;

  number_t    numbers_to_send[$];
  text_char_t expected_text[$];

  int errors        = 0;
  int cycle_count   = 0;
  int hex_numbers   = 0;
  int dec_numbers   = 0;
  int chars_checked = 0;

  // Values on the edges of the hex byte counts and of the decimal lengths.
  logic [VALUE_W-1:0] corner_values [12] = '{
    32'h0000_0000, 32'h0000_00FF, 32'h0000_0100, 32'h0000_FFFF,
    32'h0001_0000, 32'h00FF_FFFF, 32'h0100_0000, 32'h0123_4567,
    32'h89AB_CDEF, 32'd999999999, 32'd1000000000, 32'hFFFF_FFFF
  };

  integer_to_ascii_text dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the text of one number and queues its characters, the final
  // one flagged as last. Hex text always shows the low byte and shows each
  // higher byte only once the value reaches it; decimal text has no leading
  // zeros, so zero is the single character '0'.
  task automatic predict_text(input logic [VALUE_W-1:0] value, input logic mode);
    char_t              text[$];
    logic [VALUE_W-1:0] rest;
    logic [3:0]         nib;
    int                 shown_bytes;
    text_char_t         c;
    if (mode == MODE_HEX) begin
      text.push_back(CHAR_ZERO);
      text.push_back(CHAR_X);
      if (value >= 32'h0100_0000) shown_bytes = 4;
      else if (value >= 32'h0001_0000) shown_bytes = 3;
      else if (value >= 32'h0000_0100) shown_bytes = 2;
      else shown_bytes = 1;
      for (int i = 2 * shown_bytes - 1; i >= 0; i--) begin
        nib = value[4*i +: 4];
        text.push_back(nib < 4'd10 ? CHAR_ZERO + 7'(nib) : CHAR_A + 7'(nib - 4'd10));
      end
    end else begin
      rest = value;
      do begin
        text.push_front(CHAR_ZERO + 7'(rest % 10));
        rest = rest / 10;
      end while (rest != 0);
    end
    foreach (text[i]) begin
      c.code = text[i];
      c.last = (i == text.size() - 1);
      expected_text.push_back(c);
    end
  endtask

  // Driver. After each word goes in, it waits a random number of cycles
  // before offering the next one. Every so often it switches into a quiet
  // stretch where it offers words back to back.
  int   send_wait = 0;
  logic send_quiet = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (in_valid && !in_ready) begin
      // Hold the word steady until the block takes it.
    end else if (send_wait != 0) begin
      in_valid  <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (numbers_to_send.size() != 0) begin
      in_valid <= 1'b1;
      in_value <= numbers_to_send[0].value;
      in_mode  <= numbers_to_send[0].mode;
      void'(numbers_to_send.pop_front());
      if ($urandom_range(0, 24) == 0) send_quiet <= !send_quiet;
      send_wait <= send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Monitor. Predicts the text of every number the block accepts and checks
  // each character word against the oldest expectation. The result side
  // stalls for a random number of cycles after every character, with its
  // own quiet stretches where it never stalls.
  int   recv_wait = 0;
  logic recv_quiet = 1'b0;

  always @(posedge clk) begin
    int         stall;
    text_char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_value, in_mode);
        if (in_mode == MODE_HEX) hex_numbers++;
        else dec_numbers++;
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          $error("unexpected character word: char_code %0h last %0b",
                 out_char_code, out_last);
          errors++;
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            $error("char_code mismatch: expected %0h actual %0h", want.code, out_char_code);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0b actual %0b", want.last, out_last);
            errors++;
          end
        end
        if ($urandom_range(0, 40) == 0) recv_quiet <= !recv_quiet;
        stall = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          recv_wait <= stall - 1;
        end
      end else if (!out_ready) begin
        if (recv_wait == 0) out_ready <= 1'b1;
        else recv_wait <= recv_wait - 1;
      end
    end
  end

  // A run that hangs is stopped here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_to_ascii_text_tb failed");
      $finish;
    end
  end

  initial begin
    number_t            num;
    logic [VALUE_W-1:0] base;
    int                 pick;
    // Directed part: every corner value in both modes.
    foreach (corner_values[i]) begin
      num.value = corner_values[i];
      num.mode  = MODE_HEX;
      numbers_to_send.push_back(num);
      num.mode  = MODE_DEC;
      numbers_to_send.push_back(num);
    end
    // Random part: full-width values, values of random bit length so that
    // every text length shows up, values just around the byte and decade
    // boundaries, and small values.
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      case ($urandom_range(0, 3))
        0: num.value = $urandom();
        1: num.value = $urandom() >> $urandom_range(0, 31);
        2: begin
          pick = $urandom_range(0, 12);
          if (pick < 3) begin
            base = 32'h1 << (8 * (pick + 1));
          end else begin
            base = 1;
            repeat (pick - 3) base = base * 10;
          end
          num.value = base + $urandom_range(0, 4) - 2;
        end
        default: num.value = $urandom_range(0, 300);
      endcase
      num.mode = $urandom_range(0, 1) ? MODE_DEC : MODE_HEX;
      numbers_to_send.push_back(num);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (numbers_to_send.size() != 0 || in_valid || expected_text.size() != 0)
      @(posedge clk);
    // Give a stray extra character the chance to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers in hex and %0d in decimal, %0d characters checked.",
             hex_numbers, dec_numbers, chars_checked);
    $display("Both sides stalled at random, with stretches of back-to-back words.");
    if (errors == 0) begin
      $display("integer_to_ascii_text_tb passed");
    end else begin
      $display("integer_to_ascii_text_tb failed");
    end
    $finish;
  end

endmodule
